// ===== src/fdda_pkg.sv =====
// Package with shared types, register indexes and rounding helpers for the fused dot/AXPY block.
`timescale 1ns / 1ps
`default_nettype none

package fdda_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_RE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_IM = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_RE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_IM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd4;

   typedef struct packed {
      logic signed [31:0] x_re;
      logic signed [31:0] x_im;
      logic signed [31:0] u_re;
      logic signed [31:0] u_im;
      logic signed [31:0] y_re;
      logic signed [31:0] y_im;
      logic signed [31:0] z_re;
      logic signed [31:0] z_im;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_y_re;
      logic signed [31:0] new_y_im;
      logic signed [31:0] new_z_re;
      logic signed [31:0] new_z_im;
      logic signed [63:0] rho_re;
      logic signed [63:0] rho_im;
      logic               done_res;
   } rsp_type;

   // Control for the dot product accumulator.
   typedef struct packed {
      logic en;
      logic cplx;
      logic last;
   } acc_ctl_type;

   // Round a Q32.32 sum half up to Q16.16 and saturate to 32 bits.
   function automatic logic signed [31:0] round_sat32(input logic signed [65:0] v);
      logic signed [65:0] t;
      logic signed [31:0] r;
      t = v + 66'sd32768;
      t = t >>> 16;
      if ((&t[65:31]) || !(|t[65:31])) begin
         r = t[31:0];
      end else if (t[65]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   // Saturate an exact sum to the signed 64-bit range.
   function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
      logic signed [63:0] r;
      if ((&v[65:63]) || !(|v[65:63])) begin
         r = v[63:0];
      end else if (v[65]) begin
         r = 64'sh8000_0000_0000_0000;
      end else begin
         r = 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/fdda_acc.sv =====
// Running dot product accumulator with saturation and end-of-vector clear.
`timescale 1ns / 1ps
`default_nettype none

module fdda_acc (
   input  wire                      clock,
   input  wire                      reset,
   input  wire fdda_pkg::acc_ctl_type ctl,
   input  wire logic signed [63:0]  p_xr_ur,
   input  wire logic signed [63:0]  p_xi_ui,
   input  wire logic signed [63:0]  p_xr_ui,
   input  wire logic signed [63:0]  p_xi_ur,
   output logic signed [63:0]       rho_re,
   output logic signed [63:0]       rho_im
);
   import fdda_pkg::*;

   logic signed [63:0] acc_re_ff, acc_re_in;
   logic signed [63:0] acc_im_ff, acc_im_in;
   logic signed [65:0] sum_re, sum_im;
   logic signed [63:0] sat_re, sat_im;

   always_comb begin
      sum_re = 66'(acc_re_ff) + 66'(p_xr_ur) + 66'(p_xi_ui);
      sum_im = 66'(acc_im_ff) + 66'(p_xr_ui) - 66'(p_xi_ur);
      sat_re = sat64(sum_re);
      // Real mode leaves the imaginary accumulator where it was; the last item still clears it.
      sat_im = ctl.cplx ? sat64(sum_im) : acc_im_ff;
      rho_re = sat_re;
      rho_im = ctl.cplx ? sat_im : 64'sd0;
   end

   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (ctl.en) begin
         acc_re_in = ctl.last ? 64'sd0 : sat_re;
         acc_im_in = ctl.last ? 64'sd0 : sat_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff <= 64'sd0;
         acc_im_ff <= 64'sd0;
      end else begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/fused_dot_double_axpy_top.sv =====
// Top level of the fused dot product and double AXPY streaming block.
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   req_data  (x, u, y, z, last)
//   rsp       out         rsp_valid/rsp_stall   rsp_data  (new y, new z, rho, done_res)
//   csr       in          csr_we                csr_idx, csr_wdata
//
// One item per cycle while the result side is not stalled; an accepted item passes the input
// register, the product register and the result register before rsp_valid shows its result.
// The 32x32 products sit in their own register stage; the accumulator add is combinational
// from the product register to the accumulator register.
// Reset clears the accumulators, the scale registers and all stage valid bits, and sets complex mode.
// A stalled result holds the pipe only where a stage is full; bubbles still fill.
`timescale 1ns / 1ps
`default_nettype none

module fused_dot_double_axpy_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire fdda_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output fdda_pkg::rsp_type                   rsp_data,
   input  wire                                 csr_we,
   input  wire [fdda_pkg::CSR_IDX_W-1:0]       csr_idx,
   input  wire [fdda_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import fdda_pkg::*;

   // Configuration registers.
   logic signed [31:0] alpha_re_ff, alpha_im_ff, beta_re_ff, beta_im_ff;
   logic               cplx_ff;

   // Stage 1: input register.
   logic     s1_valid_ff;
   req_type  s1_data_ff;
   logic     s1_cplx_ff;

   // Stage 2: product register.
   logic               s2_valid_ff;
   logic               s2_cplx_ff, s2_last_ff;
   logic signed [31:0] s2_y_re_ff, s2_y_im_ff, s2_z_re_ff, s2_z_im_ff;
   logic signed [63:0] p_ar_xr_ff, p_ai_xi_ff, p_ar_xi_ff, p_ai_xr_ff;
   logic signed [63:0] p_br_xr_ff, p_bi_xi_ff, p_br_xi_ff, p_bi_xr_ff;
   logic signed [63:0] p_xr_ur_ff, p_xi_ui_ff, p_xr_ui_ff, p_xi_ur_ff;

   // Stage 3: result register.
   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff, rsp_data_in;

   logic s3_load, s2_load, s1_load;

   logic signed [31:0] xr, xi, ur, ui, yi, zi, ai, bi;
   logic signed [65:0] y_re_sum, y_im_sum, z_re_sum, z_im_sum;
   logic signed [63:0] rho_re, rho_im;
   acc_ctl_type        acc_ctl;

   // Each stage loads when it is empty or its item moves on.
   assign s3_load   = !rsp_valid_ff || !rsp_stall;
   assign s2_load   = !s2_valid_ff || s3_load;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = reset || !s1_load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_re_ff <= 32'sd0;
         alpha_im_ff <= 32'sd0;
         beta_re_ff  <= 32'sd0;
         beta_im_ff  <= 32'sd0;
         cplx_ff     <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_ALPHA_RE: alpha_re_ff <= csr_wdata;
            CSR_ALPHA_IM: alpha_im_ff <= csr_wdata;
            CSR_BETA_RE:  beta_re_ff  <= csr_wdata;
            CSR_BETA_IM:  beta_im_ff  <= csr_wdata;
            CSR_MODE:     cplx_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Stage 1 to 2: masking for real mode and the products.
   always_comb begin
      xr = s1_data_ff.x_re;
      ur = s1_data_ff.u_re;
      xi = s1_cplx_ff ? s1_data_ff.x_im : 32'sd0;
      ui = s1_cplx_ff ? s1_data_ff.u_im : 32'sd0;
      yi = s1_cplx_ff ? s1_data_ff.y_im : 32'sd0;
      zi = s1_cplx_ff ? s1_data_ff.z_im : 32'sd0;
      ai = s1_cplx_ff ? alpha_im_ff : 32'sd0;
      bi = s1_cplx_ff ? beta_im_ff : 32'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_load) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= req_data;
         s1_cplx_ff <= cplx_ff;
      end
      if (s2_load) begin
         s2_cplx_ff <= s1_cplx_ff;
         s2_last_ff <= s1_data_ff.last;
         s2_y_re_ff <= s1_data_ff.y_re;
         s2_y_im_ff <= yi;
         s2_z_re_ff <= s1_data_ff.z_re;
         s2_z_im_ff <= zi;
         p_ar_xr_ff <= 64'(alpha_re_ff) * 64'(xr);
         p_ai_xi_ff <= 64'(ai) * 64'(xi);
         p_ar_xi_ff <= 64'(alpha_re_ff) * 64'(xi);
         p_ai_xr_ff <= 64'(ai) * 64'(xr);
         p_br_xr_ff <= 64'(beta_re_ff) * 64'(xr);
         p_bi_xi_ff <= 64'(bi) * 64'(xi);
         p_br_xi_ff <= 64'(beta_re_ff) * 64'(xi);
         p_bi_xr_ff <= 64'(bi) * 64'(xr);
         p_xr_ur_ff <= 64'(xr) * 64'(ur);
         p_xi_ui_ff <= 64'(xi) * 64'(ui);
         p_xr_ui_ff <= 64'(xr) * 64'(ui);
         p_xi_ur_ff <= 64'(xi) * 64'(ur);
      end
      if (s3_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Stage 2 to 3: exact Q32.32 sums, then round and saturate.
   always_comb begin
      y_re_sum = 66'($signed({s2_y_re_ff, 16'h0000})) - 66'(p_ar_xr_ff) + 66'(p_ai_xi_ff);
      y_im_sum = 66'($signed({s2_y_im_ff, 16'h0000})) - 66'(p_ar_xi_ff) - 66'(p_ai_xr_ff);
      z_re_sum = 66'($signed({s2_z_re_ff, 16'h0000})) - 66'(p_br_xr_ff) + 66'(p_bi_xi_ff);
      z_im_sum = 66'($signed({s2_z_im_ff, 16'h0000})) - 66'(p_br_xi_ff) - 66'(p_bi_xr_ff);

      rsp_data_in.new_y_re = round_sat32(y_re_sum);
      rsp_data_in.new_y_im = s2_cplx_ff ? round_sat32(y_im_sum) : 32'sd0;
      rsp_data_in.new_z_re = round_sat32(z_re_sum);
      rsp_data_in.new_z_im = s2_cplx_ff ? round_sat32(z_im_sum) : 32'sd0;
      rsp_data_in.rho_re   = rho_re;
      rsp_data_in.rho_im   = rho_im;
      rsp_data_in.done_res = s2_last_ff;

      acc_ctl.en   = s2_valid_ff && s3_load;
      acc_ctl.cplx = s2_cplx_ff;
      acc_ctl.last = s2_last_ff;
   end

   fdda_acc u_acc (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .p_xr_ur (p_xr_ur_ff),
      .p_xi_ui (p_xi_ui_ff),
      .p_xr_ui (p_xr_ui_ff),
      .p_xi_ur (p_xi_ur_ff),
      .rho_re  (rho_re),
      .rho_im  (rho_im)
   );

endmodule

`default_nettype wire

// ===== src/fdda_check.sv =====
// Port-level checker for the fused dot/AXPY top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module fdda_check (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_stall,
   input wire                 rsp_valid,
   input wire                 rsp_stall,
   input wire fdda_pkg::rsp_type rsp_data
);
   import fdda_pkg::*;

   // A result that is held back stays offered.
   a_rsp_valid_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A result that is held back does not change.
   a_rsp_data_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // Reset empties the pipe.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A result appearing after an empty cycle comes from an accepted item.
   a_fill_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 3))
      else $error("result without a matching accepted item");

endmodule

bind fused_dot_double_axpy_top fdda_check u_fdda_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the fused dot product and double AXPY block.
`timescale 1ns / 1ps

module tb;
   import fdda_pkg::*;

   typedef logic signed [127:0] exact_type;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_MODE + 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = '1;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
   localparam logic signed [31:0] Q_HALF_LSB = 32'sh0000_8000;
   localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Our own copy of the registers and the dot accumulators.
   logic signed [31:0] alpha_re, alpha_im, beta_re, beta_im;
   logic cplx_mode;
   logic signed [63:0] dot_re, dot_im;

   rsp_type pending_updates[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int settings_used = 0;
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   int rsp_hold_cycles = 0;
   longint cycle_count;

   fused_dot_double_axpy_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Round half up from Q32.32 to Q16.16, then clamp to 32 bits.
   function automatic logic signed [31:0] round_q16(exact_type v);
      exact_type t;
      t = (v + 32768) >>> 16;
      if (t > exact_type'(Q_MAX)) return Q_MAX;
      if (t < exact_type'(Q_MIN)) return Q_MIN;
      return t[31:0];
   endfunction

   function automatic logic signed [63:0] sat_q32(exact_type v);
      if (v > exact_type'(ACC_MAX)) return ACC_MAX;
      if (v < exact_type'(ACC_MIN)) return ACC_MIN;
      return v[63:0];
   endfunction

   // Expected result of one element; advances the dot accumulators.
   function automatic rsp_type update_element(req_type e);
      exact_type xr, xi, ur, ui, yr, yi, zr, zi, ar, ai, br, bi;
      rsp_type r;
      xr = $signed(e.x_re);
      ur = $signed(e.u_re);
      yr = $signed(e.y_re);
      zr = $signed(e.z_re);
      ar = alpha_re;
      br = beta_re;
      xi = cplx_mode ? $signed(e.x_im) : 0;
      ui = cplx_mode ? $signed(e.u_im) : 0;
      yi = cplx_mode ? $signed(e.y_im) : 0;
      zi = cplx_mode ? $signed(e.z_im) : 0;
      ai = cplx_mode ? alpha_im : 0;
      bi = cplx_mode ? beta_im : 0;
      r.new_y_re = round_q16((yr <<< 16) - (ar * xr - ai * xi));
      r.new_y_im = cplx_mode ? round_q16((yi <<< 16) - (ar * xi + ai * xr)) : '0;
      r.new_z_re = round_q16((zr <<< 16) - (br * xr - bi * xi));
      r.new_z_im = cplx_mode ? round_q16((zi <<< 16) - (br * xi + bi * xr)) : '0;
      dot_re = sat_q32(dot_re + xr * ur + xi * ui);
      // In real mode the imaginary accumulator holds its value until the last item clears it.
      if (cplx_mode) dot_im = sat_q32(dot_im + xr * ui - xi * ur);
      r.rho_re = dot_re;
      r.rho_im = cplx_mode ? dot_im : '0;
      r.done_res = e.last;
      if (e.last) begin
         dot_re = '0;
         dot_im = '0;
      end
      return r;
   endfunction

   function automatic req_type element(logic signed [31:0] xr, xi, ur, ui, yr, yi, zr, zi,
                                       logic last);
      req_type e;
      e.x_re = xr;
      e.x_im = xi;
      e.u_re = ur;
      e.u_im = ui;
      e.y_re = yr;
      e.y_im = yi;
      e.z_re = zr;
      e.z_im = zi;
      e.last = last;
      return e;
   endfunction

   function automatic logic signed [31:0] rand_q16();
      case ($urandom_range(9))
         0: return Q_MIN;
         1: return Q_MAX;
         2: return '0;
         3: return $signed($urandom_range(32'h3FFFF, 0)) - 32'sh20000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_element(logic last);
      return element(rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                     rand_q16(), rand_q16(), rand_q16(), rand_q16(), last);
   endfunction

   task automatic send_element(req_type e);
      while (tx_idle_on && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_updates.push_back(update_element(e));
      items_sent++;
   endtask

   task automatic send_vector(int len);
      for (int i = 0; i < len; i++) send_element(rand_element(i == len - 1));
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic set_config(logic signed [31:0] a_re, a_im, b_re, b_im, logic mode);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom;
      wait_until_drained();
      write_csr(CSR_ALPHA_RE, a_re);
      write_csr(CSR_ALPHA_IM, a_im);
      write_csr(CSR_BETA_RE, b_re);
      write_csr(CSR_BETA_IM, b_im);
      // Only bit zero of the mode word counts.
      write_csr(CSR_MODE, {junk[CSR_DATA_W-1:1], mode});
      // An index past the register list must leave every register alone.
      write_csr(CSR_IDX_W'($urandom_range(CSR_SPARE_HI, CSR_SPARE_LO)), $urandom);
      csr_we <= 1'b0;
      alpha_re  = a_re;
      alpha_im  = a_im;
      beta_re   = b_re;
      beta_im   = b_im;
      cplx_mode = mode;
      settings_used++;
   endtask

   task automatic compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   task automatic check_update(rsp_type got);
      rsp_type want;
      results_seen++;
      if (pending_updates.size() == 0) begin
         $error("result arrived with no item outstanding");
         errors++;
         return;
      end
      want = pending_updates.pop_front();
      compare_field("new_y_re", want.new_y_re, got.new_y_re);
      compare_field("new_y_im", want.new_y_im, got.new_y_im);
      compare_field("new_z_re", want.new_z_re, got.new_z_re);
      compare_field("new_z_im", want.new_z_im, got.new_z_im);
      compare_field("rho_re", want.rho_re, got.rho_re);
      compare_field("rho_im", want.rho_im, got.rho_im);
      compare_field("done_res", want.done_res, got.done_res);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_update(rsp_data);
   end

   // Result side: random stalls, or a long hold when a test asks for one.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_cycles--;
         end else begin
            rsp_stall <= rx_idle_on && ($urandom_range(99) < 8);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped at the cycle limit with %0d results outstanding",
               pending_updates.size());
      $display("Some tests failed");
      $finish;
   end

   task automatic test_reset_defaults();
      // Zero scales leave y and z as they came in.
      send_element(rand_element(1'b0));
      send_element(rand_element(1'b1));
   endtask

   task automatic test_rounding_and_saturation();
      set_config(32'sd1, '0, -32'sd1, '0, 1'b1);
      // Products of exactly half an LSB, and one just below.
      send_element(element(Q_HALF_LSB, '0, '0, '0, '0, '0, '0, '0, 1'b0));
      send_element(element(-Q_HALF_LSB, '0, '0, '0, '0, '0, '0, '0, 1'b0));
      send_element(element(Q_HALF_LSB - 1, Q_HALF_LSB, '0, '0, '0, '0, '0, '0, 1'b0));
      send_element(element(-Q_HALF_LSB, Q_HALF_LSB, '0, '0, Q_ONE, '0, Q_ONE, '0, 1'b1));
      set_config(Q_MAX, Q_MAX, Q_MIN, Q_MIN, 1'b1);
      send_element(element(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 1'b0));
      send_element(element(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
      send_element(element(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
   endtask

   task automatic test_accumulator_saturation();
      set_config(Q_ONE, -Q_ONE, Q_HALF_LSB, Q_MAX, 1'b1);
      // Each vector drives one accumulator past one end of its range.
      repeat (2) send_element(element(Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0, '0, '0, '0, 1'b0));
      send_element(element(Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0, '0, '0, '0, 1'b1));
      send_element(element(Q_MIN, Q_MIN, Q_MIN, Q_MAX, '0, '0, '0, '0, 1'b0));
      send_element(element(Q_MIN, Q_MIN, Q_MIN, Q_MAX, '0, '0, '0, '0, 1'b1));
      send_element(element(Q_MIN, Q_MIN, Q_MAX, Q_MIN, '0, '0, '0, '0, 1'b0));
      send_element(element(Q_MIN, Q_MIN, Q_MAX, Q_MIN, '0, '0, '0, '0, 1'b1));
      send_element(element(Q_MIN, Q_MAX, Q_MAX, Q_MIN, '0, '0, '0, '0, 1'b0));
      send_element(element(Q_MIN, Q_MAX, Q_MAX, Q_MIN, '0, '0, '0, '0, 1'b1));
   endtask

   task automatic test_real_mode();
      set_config(Q_ONE, Q_MAX, Q_MIN, Q_ONE, 1'b0);
      send_element(rand_element(1'b0));
      send_element(rand_element(1'b1));
      // Switch modes in the middle of one vector; the sums carry on.
      set_config(Q_ONE, Q_MAX, Q_MIN, Q_ONE, 1'b1);
      send_element(rand_element(1'b0));
      set_config(Q_ONE, Q_MAX, Q_MIN, Q_ONE, 1'b0);
      send_element(rand_element(1'b0));
      set_config(-Q_ONE, Q_MIN, Q_MAX, -Q_ONE, 1'b1);
      send_element(rand_element(1'b1));
   endtask

   task automatic test_random_vectors();
      int sent;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: set_config(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1);
            1: set_config(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
            2: set_config(Q_MIN, Q_MAX, Q_MAX, Q_MIN, 1'b1);
            default: set_config(rand_q16(), rand_q16(), rand_q16(), rand_q16(), phase[0]);
         endcase
         sent = 0;
         while (sent < 100) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
            send_vector(len);
            sent += len;
         end
      end
   endtask

   task automatic test_no_idle_stretch();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      set_config(rand_q16(), rand_q16(), rand_q16(), rand_q16(), 1'b1);
      repeat (15) send_vector($urandom_range(14, 6));
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   task automatic test_result_backpressure();
      tx_idle_on = 1'b0;
      set_config(rand_q16(), rand_q16(), rand_q16(), rand_q16(), 1'b1);
      // Items keep coming while results are held, so the pipe fills and stalls.
      rsp_hold_cycles = 200;
      repeat (6) send_vector(10);
      tx_idle_on = 1'b1;
   endtask

   initial begin
      alpha_re  = '0;
      alpha_im  = '0;
      beta_re   = '0;
      beta_im   = '0;
      cplx_mode = 1'b1;
      dot_re    = '0;
      dot_im    = '0;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_idx   <= '0;
      csr_wdata <= '0;
      reset     <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_rounding_and_saturation();
      test_accumulator_saturation();
      test_real_mode();
      test_random_vectors();
      test_no_idle_stretch();
      test_result_backpressure();

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d items and %0d results over %0d register settings,",
               items_sent, results_seen, settings_used);
      $display("with rounding ties, y, z and rho saturation, real mode and a long result hold.");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
